// ----- sv/psq_pkg.sv -----
// shared types and codes of the parity split stack and queue
package psq_pkg;

    localparam int unsigned CMD_QUEUE_DEPTH = 4;
    localparam int unsigned CQ_AW = $clog2(CMD_QUEUE_DEPTH);

    typedef enum logic [1:0] {
        K_INSERT     = 2'd0,
        K_SHOW_QUEUE = 2'd1,
        K_SHOW_STACK = 2'd2,
        K_SHOW_BOTH  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_PUSH_STACK = 3'd0,
        OP_PUSH_QUEUE = 3'd1,
        OP_SHOW_QUEUE = 3'd2,
        OP_SHOW_STACK = 3'd3,
        OP_SHOW_BOTH  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_STACK = 3'd0,
        ST_QUEUE = 3'd1,
        ST_FULL  = 3'd2,
        ST_ELEM  = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    localparam logic SRC_STACK = 1'b0;
    localparam logic SRC_QUEUE = 1'b1;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

endpackage

// ----- sv/parity_split_stack_and_queue.sv -----
// top level of the parity split stack and queue
// Even values go onto a stack and odd values into a first-in-first-out queue, each holding
// up to DEPTH entries; a full store drops the value and says so. An insert gives one status
// item; inserts run at one per cycle when no show run is under way and the output is free.
// A show request sets up its run, then emits an item per cycle while the output is free (one
// item for an empty store), paced by the single read port of each store and the sequencer. A
// four-entry command queue between the input side and the sequencer lets items be taken
// while a run is being emitted. The stores need no clearing after reset.
module parity_split_stack_and_queue
    import psq_pkg::*;
#(
    parameter int unsigned DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_value,
    output logic               o_stall,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic               o_source,
    output logic signed [31:0] o_element,
    output logic               o_last,
    input  logic               i_stall
);

    t_cmd_chan w_cmd;
    logic      w_cmd_pop;

    psq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_kind    (i_kind),
        .i_value   (i_value),
        .o_stall   (o_stall),
        .o_cmd     (w_cmd),
        .i_cmd_pop (w_cmd_pop)
    );

    psq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_cmd_pop (w_cmd_pop),
        .o_valid   (o_valid),
        .o_status  (o_status),
        .o_source  (o_source),
        .o_element (o_element),
        .o_last    (o_last),
        .i_stall   (i_stall)
    );

endmodule

// ----- sv/psq_front.sv -----
// front end: takes items, sorts them into commands and queues them for the back end
module psq_front
    import psq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_value,
    output logic               o_stall,
    output t_cmd_chan          o_cmd,
    input  logic               i_cmd_pop
);

    t_cmd             r_q [CMD_QUEUE_DEPTH];
    logic [CQ_AW-1:0] r_wp, n_wp;
    logic [CQ_AW-1:0] r_rp, n_rp;
    logic [CQ_AW:0]   r_cnt, n_cnt;
    t_cmd             w_cmd;
    logic             w_push;

    always_comb begin
        w_cmd.value = i_value;
        case (t_kind'(i_kind))
            K_INSERT:     w_cmd.op = i_value[0] ? OP_PUSH_QUEUE : OP_PUSH_STACK;
            K_SHOW_QUEUE: w_cmd.op = OP_SHOW_QUEUE;
            K_SHOW_STACK: w_cmd.op = OP_SHOW_STACK;
            default:      w_cmd.op = OP_SHOW_BOTH;
        endcase
    end

    assign o_stall   = (r_cnt == (CQ_AW+1)'(CMD_QUEUE_DEPTH));
    assign w_push    = i_valid && !o_stall;
    assign o_cmd.valid = (r_cnt != '0);
    assign o_cmd.cmd   = r_q[r_rp];

    always_comb begin
        n_wp  = w_push ? CQ_AW'(r_wp + 1'b1) : r_wp;
        n_rp  = i_cmd_pop ? CQ_AW'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        if (w_push && !i_cmd_pop) begin
            n_cnt = (CQ_AW+1)'(r_cnt + 1'b1);
        end else if (!w_push && i_cmd_pop) begin
            n_cnt = (CQ_AW+1)'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ----- sv/psq_back.sv -----
// back end: stores, sequencer for show runs, read stage and output register
module psq_back
    import psq_pkg::*;
#(
    parameter int unsigned DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd_chan          i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic               o_source,
    output logic signed [31:0] o_element,
    output logic               o_last,
    input  logic               i_stall
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_STACK = 3'b010,
        S_QUEUE = 3'b100
    } t_bstate;

    logic signed [31:0] r_smem [DEPTH];
    logic signed [31:0] r_qmem [DEPTH];

    t_bstate            r_state, n_state;
    logic [CW-1:0]      r_scnt, n_scnt;
    logic [CW-1:0]      r_qcnt, n_qcnt;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_both, n_both;

    logic               r_f_valid;
    t_status            r_f_status;
    logic               r_f_source;
    logic               r_f_last;
    logic               r_f_elem;
    logic signed [31:0] r_rd_s;
    logic signed [31:0] r_rd_q;

    logic               r_o_valid;
    t_status            r_o_status;
    logic               r_o_source;
    logic signed [31:0] r_o_element;
    logic               r_o_last;

    logic               w_out_free;
    logic               w_adv;
    logic               w_step;
    t_status            w_status;
    logic               w_source;
    logic               w_last;
    logic               w_elem;
    logic               w_swe, w_qwe, w_sre, w_qre;
    logic [AW-1:0]      w_saddr, w_qaddr;
    logic [CW-1:0]      w_idx_dn;

    assign w_out_free = !r_o_valid || !i_stall;
    assign w_adv      = !r_f_valid || w_out_free;
    assign w_idx_dn   = CW'(r_idx - 1'b1);

    always_comb begin
        n_state   = r_state;
        n_scnt    = r_scnt;
        n_qcnt    = r_qcnt;
        n_idx     = r_idx;
        n_both    = r_both;
        o_cmd_pop = 1'b0;
        w_step    = 1'b0;
        w_status  = ST_EMPTY;
        w_source  = SRC_STACK;
        w_last    = 1'b0;
        w_elem    = 1'b0;
        w_swe     = 1'b0;
        w_qwe     = 1'b0;
        w_sre     = 1'b0;
        w_qre     = 1'b0;
        w_saddr   = r_scnt[AW-1:0];
        w_qaddr   = r_qcnt[AW-1:0];
        if (w_adv) begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        o_cmd_pop = 1'b1;
                        case (i_cmd.cmd.op)
                            OP_PUSH_STACK: begin
                                w_step   = 1'b1;
                                w_source = SRC_STACK;
                                w_last   = 1'b1;
                                if (r_scnt == CW'(DEPTH)) begin
                                    w_status = ST_FULL;
                                end else begin
                                    w_status = ST_STACK;
                                    w_swe    = 1'b1;
                                    n_scnt   = CW'(r_scnt + 1'b1);
                                end
                            end
                            OP_PUSH_QUEUE: begin
                                w_step   = 1'b1;
                                w_source = SRC_QUEUE;
                                w_last   = 1'b1;
                                if (r_qcnt == CW'(DEPTH)) begin
                                    w_status = ST_FULL;
                                end else begin
                                    w_status = ST_QUEUE;
                                    w_qwe    = 1'b1;
                                    n_qcnt   = CW'(r_qcnt + 1'b1);
                                end
                            end
                            OP_SHOW_QUEUE: begin
                                n_state = S_QUEUE;
                                n_idx   = '0;
                                n_both  = 1'b0;
                            end
                            OP_SHOW_STACK: begin
                                n_state = S_STACK;
                                n_idx   = r_scnt;
                                n_both  = 1'b0;
                            end
                            default: begin
                                n_state = S_STACK;
                                n_idx   = r_scnt;
                                n_both  = 1'b1;
                            end
                        endcase
                    end
                end
                S_STACK: begin
                    w_step   = 1'b1;
                    w_source = SRC_STACK;
                    if (r_scnt == '0) begin
                        w_status = ST_EMPTY;
                        w_last   = !r_both;
                        n_state  = r_both ? S_QUEUE : S_IDLE;
                        n_idx    = '0;
                    end else begin
                        w_status = ST_ELEM;
                        w_elem   = 1'b1;
                        w_sre    = 1'b1;
                        w_saddr  = w_idx_dn[AW-1:0];
                        n_idx    = w_idx_dn;
                        if (r_idx == CW'(1)) begin
                            w_last  = !r_both;
                            n_state = r_both ? S_QUEUE : S_IDLE;
                            n_idx   = '0;
                        end
                    end
                end
                S_QUEUE: begin
                    w_step   = 1'b1;
                    w_source = SRC_QUEUE;
                    if (r_qcnt == '0) begin
                        w_status = ST_EMPTY;
                        w_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        w_status = ST_ELEM;
                        w_elem   = 1'b1;
                        w_qre    = 1'b1;
                        w_qaddr  = r_idx[AW-1:0];
                        n_idx    = CW'(r_idx + 1'b1);
                        if (CW'(r_idx + 1'b1) == r_qcnt) begin
                            w_last  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_scnt    <= '0;
            r_qcnt    <= '0;
            r_idx     <= '0;
            r_both    <= 1'b0;
            r_f_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scnt  <= n_scnt;
            r_qcnt  <= n_qcnt;
            r_idx   <= n_idx;
            r_both  <= n_both;
            if (w_adv) begin
                r_f_valid <= w_step;
            end
            if (w_out_free) begin
                r_o_valid <= r_f_valid;
            end
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_status <= w_status;
            r_f_source <= w_source;
            r_f_last   <= w_last;
            r_f_elem   <= w_elem;
        end
    end

    // stack store
    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_smem[w_saddr] <= i_cmd.cmd.value;
        end
        if (w_sre) begin
            r_rd_s <= r_smem[w_saddr];
        end
    end

    // queue store
    always_ff @(posedge i_clk) begin
        if (w_qwe) begin
            r_qmem[w_qaddr] <= i_cmd.cmd.value;
        end
        if (w_qre) begin
            r_rd_q <= r_qmem[w_qaddr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_out_free && r_f_valid) begin
            r_o_status  <= r_f_status;
            r_o_source  <= r_f_source;
            r_o_last    <= r_f_last;
            r_o_element <= !r_f_elem ? 32'sd0 :
                           ((r_f_source == SRC_QUEUE) ? r_rd_q : r_rd_s);
        end
    end

    assign o_valid   = r_o_valid;
    assign o_status  = r_o_status;
    assign o_source  = r_o_source;
    assign o_element = r_o_element;
    assign o_last    = r_o_last;

endmodule

// ----- dv/tb_parity_split_stack_and_queue.sv -----
// self-checking testbench of the parity split stack and queue with a scoreboard class
module tb_parity_split_stack_and_queue;
    import psq_pkg::*;

    localparam int unsigned DEPTH = 32;
    localparam int unsigned RANDOM_ITEMS = 390;

    typedef struct packed {
        t_status            status;
        logic               source;
        logic signed [31:0] element;
        logic               last;
    } t_result;

    class psq_scoreboard;
        logic signed [31:0] stack_vals [DEPTH];
        logic signed [31:0] queue_vals [DEPTH];
        int unsigned        stack_fill = 0;
        int unsigned        queue_fill = 0;
        t_result            pending [$];
        int unsigned        mismatches = 0;
        int unsigned        checked = 0;
        int unsigned        drops = 0;

        function void add_result(t_status status, logic source, logic signed [31:0] element);
            t_result r;
            r.status  = status;
            r.source  = source;
            r.element = element;
            r.last    = 1'b0;
            pending.push_back(r);
        endfunction

        function void list_stack();
            if (stack_fill == 0) begin
                add_result(ST_EMPTY, SRC_STACK, '0);
            end else begin
                for (int i = int'(stack_fill) - 1; i >= 0; i--)
                    add_result(ST_ELEM, SRC_STACK, stack_vals[i]);
            end
        endfunction

        function void list_queue();
            if (queue_fill == 0) begin
                add_result(ST_EMPTY, SRC_QUEUE, '0);
            end else begin
                for (int i = 0; i < int'(queue_fill); i++)
                    add_result(ST_ELEM, SRC_QUEUE, queue_vals[i]);
            end
        endfunction

        function void note_item(t_kind kind, logic signed [31:0] value);
            case (kind)
                K_INSERT: begin
                    if (!value[0]) begin
                        if (stack_fill >= DEPTH) begin
                            add_result(ST_FULL, SRC_STACK, '0);
                            drops++;
                        end else begin
                            stack_vals[stack_fill] = value;
                            stack_fill++;
                            add_result(ST_STACK, SRC_STACK, '0);
                        end
                    end else begin
                        if (queue_fill >= DEPTH) begin
                            add_result(ST_FULL, SRC_QUEUE, '0);
                            drops++;
                        end else begin
                            queue_vals[queue_fill] = value;
                            queue_fill++;
                            add_result(ST_QUEUE, SRC_QUEUE, '0);
                        end
                    end
                end
                K_SHOW_QUEUE: list_queue();
                K_SHOW_STACK: list_stack();
                default: begin
                    list_stack();
                    list_queue();
                end
            endcase
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [2:0] status, logic source,
                                   logic signed [31:0] element, logic last);
            t_result exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item status %0d source %0d element %0d last %0d",
                         $time, status, source, element, last);
                mismatches++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (status !== exp.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
                mismatches++;
            end
            if (source !== exp.source) begin
                $display("%0t: source expected %0d actual %0d", $time, exp.source, source);
                mismatches++;
            end
            if (element !== exp.element) begin
                $display("%0t: element expected %0d actual %0d", $time, exp.element, element);
                mismatches++;
            end
            if (last !== exp.last) begin
                $display("%0t: last expected %0d actual %0d", $time, exp.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [1:0]         i_kind = 2'd0;
    logic signed [31:0] i_value = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [2:0]         o_status;
    logic               o_source;
    logic signed [31:0] o_element;
    logic               o_last;

    psq_scoreboard sb = new();
    int unsigned kind_count [4] = '{0, 0, 0, 0};
    int unsigned stall_mode = 0;
    int unsigned mode_cycles = 0;

    parity_split_stack_and_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .i_value  (i_value),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_source (o_source),
        .o_element(o_element),
        .o_last   (o_last),
        .i_stall  (i_stall)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("timeout with %0d result items outstanding", sb.pending.size());
        $display("FAILURE");
        $finish;
    end

    // receiver back-pressure: free-running, light and heavy stretches
    always @(posedge i_clk) begin
        if (mode_cycles == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            mode_cycles <= $urandom_range(40, 300);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_status, o_source, o_element, o_last);
    end

    task automatic send_item(input t_kind kind, input logic signed [31:0] value);
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_item(kind, value);
        kind_count[kind]++;
    endtask

    task automatic idle_for(input int unsigned cycles);
        if (cycles != 0) begin
            i_valid <= 1'b0;
            i_value <= $urandom;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'sh0000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0000;
            3: return 32'shffff_ffff;
            4: return 32'shffff_fffe;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned sent;
        int unsigned burst;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty stores first, then extremes of sign and parity
        send_item(K_SHOW_BOTH, 32'sh1234_5679);
        send_item(K_SHOW_QUEUE, '0);
        send_item(K_SHOW_STACK, 32'shffff_ffff);
        send_item(K_INSERT, 32'sh0000_0000);
        send_item(K_INSERT, 32'shffff_ffff);
        send_item(K_INSERT, 32'sh7fff_ffff);
        send_item(K_INSERT, 32'sh8000_0000);
        send_item(K_INSERT, 32'sh0000_0001);
        send_item(K_INSERT, 32'shffff_fffe);
        send_item(K_INSERT, 32'sh5555_5555);
        send_item(K_INSERT, 32'shaaaa_aaaa);
        send_item(K_SHOW_STACK, 32'sh5555_5555);
        idle_for(3);
        send_item(K_SHOW_QUEUE, 32'shaaaa_aaaa);
        send_item(K_INSERT, 32'sh8000_0001);
        send_item(K_INSERT, 32'sh7fff_fffe);
        send_item(K_SHOW_BOTH, 32'shffff_ffff);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < int'(burst) && sent < RANDOM_ITEMS; b++) begin
                if ($urandom_range(0, 99) < 68)
                    send_item(K_INSERT, pick_value());
                else
                    send_item(t_kind'($urandom_range(1, 3)), $urandom);
                sent++;
                if (sent == RANDOM_ITEMS / 2)
                    wait_drained();
            end
            if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 6));
        end

        wait_drained();
        repeat (16) @(posedge i_clk);

        $display("items: %0d inserts (%0d dropped on a full store), %0d show queue, %0d show stack,",
                 kind_count[K_INSERT], sb.drops, kind_count[K_SHOW_QUEUE],
                 kind_count[K_SHOW_STACK]);
        $display("%0d show both; %0d result items checked, %0d mismatches",
                 kind_count[K_SHOW_BOTH], sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/psq_pkg.sv
sv/psq_front.sv
sv/psq_back.sv
sv/parity_split_stack_and_queue.sv
dv/tb_parity_split_stack_and_queue.sv
